FILE: sv/hypo_pkg.sv
// Shared constants, tables and helper functions for the hypotrochoid point generator.
package hypo_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 18;
    localparam int ATAN_DEPTH = 24;

    localparam logic signed [20:0] STEP_Q16 = 21'sd655;
    localparam logic signed [20:0] PI_Q16 = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [27:0] GAIN_Q24 = 28'sd10188014;
    localparam logic [41:0] TWO_HUNDRED_PI_Q32 = 42'd2698607540904;
    localparam logic signed [18:0] OUT_MAX = 19'sd262143;
    localparam logic signed [17:0] OFFSET_MAX = 18'sd131071;
    localparam logic signed [17:0] OFFSET_MIN = 18'sh20000;

    localparam logic [0:0] ACT_START = 1'b0;
    localparam logic [0:0] ACT_NEXT = 1'b1;

    localparam logic [0:0] CFG_TOOTH_COUNT = 1'b0;
    localparam logic [0:0] CFG_RING_RADIUS = 1'b1;

    // Arctangent table at 24 fraction bits
    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0: v = 24'd13176795;
            5'd1: v = 24'd7778716;
            5'd2: v = 24'd4110060;
            5'd3: v = 24'd2086331;
            5'd4: v = 24'd1047214;
            5'd5: v = 24'd524117;
            5'd6: v = 24'd262123;
            5'd7: v = 24'd131069;
            5'd8: v = 24'd65536;
            5'd9: v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // Wrap a value known to lie within one period outside [-pi, pi]
    function automatic logic signed [19:0] wrap_once(input logic signed [24:0] a);
        logic signed [24:0] r;
        r = a;
        if (r > 25'(PI_Q16))
        begin
            r = r - 25'(TWO_PI_Q16);
        end
        else if (r < -25'(PI_Q16))
        begin
            r = r + 25'(TWO_PI_Q16);
        end
        return r[19:0];
    endfunction

endpackage

FILE: sv/hypo_cordic.sv
// Iterative CORDIC: cos and sin of a Q4.16 angle in [-pi, pi], results in Q24.
module hypo_cordic #(
    parameter int ITERATIONS = hypo_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [19:0]  angle,
    output logic                done,
    output logic signed [27:0]  cos_q24,
    output logic signed [27:0]  sin_q24
);
    import hypo_pkg::*;

    localparam int IW = $clog2(ITERATIONS + 1);

    logic               busy_reg, busy_next;
    logic [IW-1:0]      iter_reg, iter_next;
    logic               neg_reg, neg_next;
    logic signed [27:0] x_reg, x_next;
    logic signed [27:0] y_reg, y_next;
    logic signed [28:0] z_reg, z_next;
    logic signed [20:0] ang_fold;
    logic               fold_neg;
    logic signed [27:0] dx, dy;
    logic signed [28:0] at;
    logic signed [27:0] x_step, y_step;
    logic signed [28:0] z_step;

    always_comb
    begin
        fold_neg = 1'b0;
        ang_fold = 21'(angle);
        if (21'(angle) > HALF_PI_Q16)
        begin
            ang_fold = 21'(angle) - PI_Q16;
            fold_neg = 1'b1;
        end
        else if (21'(angle) < -HALF_PI_Q16)
        begin
            ang_fold = 21'(angle) + PI_Q16;
            fold_neg = 1'b1;
        end
    end

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = 29'(atan_q24(5'(iter_reg)));

    // one rotation step on the current vector
    assign x_step = (z_reg >= 0) ? x_reg - dx : x_reg + dx;
    assign y_step = (z_reg >= 0) ? y_reg + dy : y_reg - dy;
    assign z_step = (z_reg >= 0) ? z_reg - at : z_reg + at;

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        neg_next = neg_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            neg_next = fold_neg;
            x_next = GAIN_Q24;
            y_next = '0;
            z_next = {ang_fold, 8'd0};
        end
        else if (busy_reg)
        begin
            x_next = x_step;
            y_next = y_step;
            z_next = z_step;
            iter_next = iter_reg + 1'b1;
            if (iter_reg == IW'(ITERATIONS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = busy_reg && (iter_reg == IW'(ITERATIONS - 1));
    assign cos_q24 = neg_reg ? -x_step : x_step;
    assign sin_q24 = neg_reg ? -y_step : y_step;

    assert property (@(posedge clk) disable iff (!rst_n) done && !start |=> !busy_reg)
        else $error("cordic still busy after done");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |-> iter_reg < IW'(ITERATIONS))
        else $error("cordic iteration count overran");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("cordic failed to start");

endmodule

FILE: sv/hypotrochoid_point_generator_core.sv
// Hypotrochoid point generator top level: start setup sequencer, point sequencer and output.
// Start item: gcd by repeated subtraction (up to 254 steps), three serial 25-step divides and a
//   point count multiply run before the next item is taken; a zero tooth count skips them.
// Next item: two passes of one shared CORDIC, four serial products through one multiplier,
//   then the sum, which waits for the output register to free up.
// The result sits in an output register; the next item is accepted while it waits.
// rst_n asynchronously clears control and curve state and restores config defaults, not scratch.
module hypotrochoid_point_generator_core #(
    parameter int CORDIC_ITERATIONS = hypo_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // wheel_tooth_count[7:0], start_angle[27:8], pen_distance[43:28]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // point_x[18:0], point_y[37:19], zero fill
    output logic        m_tlast,   // last_point
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hypo_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_GCD    = 4'd1;
    localparam logic [3:0] ST_DIVOFF = 4'd2;
    localparam logic [3:0] ST_DIVINC = 4'd3;
    localparam logic [3:0] ST_DIVROT = 4'd4;
    localparam logic [3:0] ST_STEPS  = 4'd5;
    localparam logic [3:0] ST_CRING  = 4'd6;
    localparam logic [3:0] ST_CPEN   = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_SUM    = 4'd9;

    logic [7:0]         outer_teeth_reg;
    logic [15:0]        ring_radius_reg;
    logic signed [19:0] ring_angle_reg, pen_angle_reg;
    logic signed [23:0] pen_inc_reg;
    logic signed [17:0] offset_reg;
    logic [15:0]        pen_radius_reg;
    logic [17:0]        steps_left_reg;
    logic [3:0]         state_reg;

    // setup scratch
    logic [7:0]         ga_reg, gb_reg, wt_reg;
    logic               dneg_reg;
    logic [24:0]        dnum_reg;
    logic [24:0]        drem_reg;
    logic [7:0]         dden_reg;
    logic [4:0]         dcnt_reg;
    logic [7:0]         rot_reg;

    // point scratch
    logic signed [27:0] rc_reg, rs_reg, pc_reg, ps_reg;
    logic [1:0]         mcnt_reg;
    logic signed [27:0] prod_reg [4];
    logic               out_valid_reg;
    logic signed [18:0] out_x_reg, out_y_reg;
    logic               out_last_reg;

    logic               in_acc;
    logic               cstart;
    logic signed [19:0] cangle;
    logic               cdone;
    logic signed [27:0] ccos, csin;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc = s_tvalid && s_tready;

    assign cstart = (in_acc && s_tuser == ACT_NEXT && steps_left_reg != 0)
                 || (state_reg == ST_CRING && cdone);
    assign cangle = (state_reg == ST_CRING) ? pen_angle_reg : ring_angle_reg;

    hypo_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .angle(cangle),
        .done(cdone), .cos_q24(ccos), .sin_q24(csin)
    );

    // shared restoring divider step
    logic [25:0] dtrial;
    logic [24:0] drem_sh;
    assign drem_sh = {drem_reg[23:0], dnum_reg[24]};
    assign dtrial = {1'b0, drem_sh} - {18'd0, dden_reg};

    // shared multiplier: 18x28 operand select
    logic signed [17:0] mop_a;
    logic signed [27:0] mop_b;
    logic signed [46:0] mprod;
    always_comb
    begin
        unique case (mcnt_reg)
            2'd0: begin mop_a = offset_reg; mop_b = rc_reg; end
            2'd1: begin mop_a = $signed({2'b0, pen_radius_reg}); mop_b = pc_reg; end
            2'd2: begin mop_a = offset_reg; mop_b = rs_reg; end
            default: begin mop_a = $signed({2'b0, pen_radius_reg}); mop_b = ps_reg; end
        endcase
    end
    assign mprod = mop_a * mop_b + 47'sd8388608;

    logic signed [28:0] sx, sy;
    assign sx = 29'(prod_reg[0]) + 29'(prod_reg[1]);
    assign sy = 29'(prod_reg[2]) - 29'(prod_reg[3]);

    function automatic logic signed [18:0] sat19(input logic signed [28:0] v);
        if (v > 29'(OUT_MAX)) return OUT_MAX;
        if (v < -29'(OUT_MAX)) return -OUT_MAX;
        return v[18:0];
    endfunction

    logic [7:0]         in_wt;
    logic signed [19:0] in_sa;
    logic signed [8:0]  diff;
    logic [24:0]        diff_abs_mag;
    logic [24:0]        rounded;
    logic [49:0]        steps_prod;
    assign in_wt = s_tdata[7:0];
    assign in_sa = $signed(s_tdata[27:8]);
    assign diff = $signed({1'b0, outer_teeth_reg}) - $signed({1'b0, wt_reg});
    assign diff_abs_mag = 25'(diff[8] ? -diff : diff);
    // quotient plus rounding: remainder*2 >= den rounds away
    assign rounded = dnum_reg + 25'(({drem_reg, 1'b0} >= {18'd0, dden_reg}) ? 1 : 0);
    assign steps_prod = 50'(rot_reg) * 50'(TWO_HUNDRED_PI_Q32) + 50'h0FFFFFFFF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_teeth_reg <= 8'd96;
            ring_radius_reg <= 16'd25600;
            ring_angle_reg <= '0;
            pen_angle_reg <= '0;
            pen_inc_reg <= '0;
            offset_reg <= '0;
            pen_radius_reg <= '0;
            steps_left_reg <= '0;
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOOTH_COUNT: outer_teeth_reg <= cfg_data[7:0];
                    default: ring_radius_reg <= cfg_data;
                endcase
            end
            if (m_tvalid && m_tready && state_reg != ST_SUM)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && s_tuser == ACT_START)
                    begin
                        pen_radius_reg <= s_tdata[43:28];
                        ring_angle_reg <= wrap_once(25'(in_sa));
                        pen_angle_reg <= wrap_once(25'(in_sa));
                        wt_reg <= in_wt;
                        if (outer_teeth_reg == 0 || in_wt == 0)
                        begin
                            pen_inc_reg <= '0;
                            offset_reg <= '0;
                            steps_left_reg <= '0;
                        end
                        else
                        begin
                            ga_reg <= outer_teeth_reg;
                            gb_reg <= in_wt;
                            state_reg <= ST_GCD;
                        end
                    end
                    else if (in_acc && steps_left_reg != 0)
                    begin
                        state_reg <= ST_CRING;
                    end
                end
                ST_GCD:
                begin
                    // subtractive gcd
                    if (ga_reg == gb_reg)
                    begin
                        dneg_reg <= diff[8];
                        dnum_reg <= 25'(ring_radius_reg) * diff_abs_mag;
                        drem_reg <= '0;
                        dden_reg <= outer_teeth_reg;
                        dcnt_reg <= '0;
                        state_reg <= ST_DIVOFF;
                    end
                    else if (ga_reg > gb_reg)
                    begin
                        ga_reg <= ga_reg - gb_reg;
                    end
                    else
                    begin
                        gb_reg <= gb_reg - ga_reg;
                    end
                end
                ST_DIVOFF, ST_DIVINC, ST_DIVROT:
                begin
                    if (dcnt_reg != 5'd25)
                    begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        dnum_reg <= {dnum_reg[23:0], ~dtrial[25]};
                        drem_reg <= dtrial[25] ? drem_sh : dtrial[24:0];
                    end
                    else
                    begin
                        dcnt_reg <= '0;
                        drem_reg <= '0;
                        if (state_reg == ST_DIVOFF)
                        begin
                            if (dneg_reg)
                            begin
                                offset_reg <= (rounded > 25'd131072) ? OFFSET_MIN
                                    : 18'(-$signed({1'b0, rounded}));
                            end
                            else
                            begin
                                offset_reg <= (rounded > 25'd131071) ? OFFSET_MAX
                                    : 18'(rounded);
                            end
                            dnum_reg <= 25'(diff_abs_mag) * 25'd655;
                            dden_reg <= wt_reg;
                            state_reg <= ST_DIVINC;
                        end
                        else if (state_reg == ST_DIVINC)
                        begin
                            pen_inc_reg <= dneg_reg ? 24'(-$signed({1'b0, rounded}))
                                : 24'(rounded);
                            dnum_reg <= 25'(outer_teeth_reg);
                            dden_reg <= ga_reg;
                            state_reg <= ST_DIVROT;
                        end
                        else
                        begin
                            rot_reg <= dnum_reg[7:0];
                            state_reg <= ST_STEPS;
                        end
                    end
                end
                ST_STEPS:
                begin
                    steps_left_reg <= steps_prod[49:32];
                    state_reg <= ST_IDLE;
                end
                ST_CRING:
                begin
                    if (cdone)
                    begin
                        rc_reg <= ccos;
                        rs_reg <= csin;
                        state_reg <= ST_CPEN;
                    end
                end
                ST_CPEN:
                begin
                    if (cdone)
                    begin
                        pc_reg <= ccos;
                        ps_reg <= csin;
                        mcnt_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg[mcnt_reg] <= 28'(mprod >>> 24);
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 2'd3)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    // hold the point until the output register frees up
                    if (!out_valid_reg || m_tready)
                    begin
                        out_x_reg <= sat19(sx);
                        out_y_reg <= sat19(sy);
                        out_last_reg <= (steps_left_reg == 18'd1);
                        out_valid_reg <= 1'b1;
                        steps_left_reg <= steps_left_reg - 1'b1;
                        ring_angle_reg <= wrap_once(25'(ring_angle_reg) + 25'(STEP_Q16));
                        pen_angle_reg <= wrap_once(25'(pen_angle_reg) + 25'(pen_inc_reg));
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_y_reg, out_x_reg};
    assign m_tlast = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |=> out_valid_reg)
        else $error("point not presented after sum");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> steps_left_reg != 0)
        else $error("point produced with no steps left");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> ga_reg != 0 && gb_reg != 0)
        else $error("gcd operand reached zero");

endmodule
